>>> hdl/cfcid_pkg.sv
// Shared types and constants for the card frame checker and ID allow-list.
// Holds frame layout constants, job and status codes, and the back-end states.
// No dependencies; every other file in hdl imports this package.
package cfcid_pkg;

  // Frame layout
  localparam int unsigned FRAME_BYTES = 15;
  localparam int unsigned POS_W       = 4;
  localparam logic [POS_W-1:0] POS_FIRST  = 4'd0;
  localparam logic [POS_W-1:0] POS_ID_LO  = 4'(FRAME_BYTES - 6);
  localparam logic [POS_W-1:0] POS_ID_HI  = 4'(FRAME_BYTES - 3);
  localparam logic [POS_W-1:0] POS_CHECK  = 4'(FRAME_BYTES - 2);
  localparam logic [POS_W-1:0] POS_LAST   = 4'(FRAME_BYTES - 1);
  localparam logic [POS_W-1:0] POS_END    = 4'(FRAME_BYTES);

  localparam logic [7:0] START_MARK = 8'h0f;
  localparam logic [7:0] END_MARK   = 8'h03;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_ENROLL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX    = 2'd1;
  localparam logic [7:0] MAX_CARDS_RST = 8'd99;

  // Work passed from the frame parser to the list engine
  typedef enum logic [1:0] {
    JOB_ERASE,
    JOB_BAD,
    JOB_ENROLL,
    JOB_CHECK
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [31:0] id;
  } job_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_BAD      = 3'd0,
    ST_ENROLLED = 3'd1,
    ST_DUP      = 3'd2,
    ST_FULL     = 3'd3,
    ST_GRANTED  = 3'd4,
    ST_UNKNOWN  = 3'd5,
    ST_ERASED   = 3'd6
  } status_t;

  // Job queue depth
  localparam int unsigned Q_DEPTH = 2;

  // List engine states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SEARCH,
    BK_EMIT
  } back_state_t;

endpackage

>>> hdl/card_frame_check_and_id_allowlist_core.sv
// Card frame checker and ID allow-list: one input beat per frame byte or erase.
// Erase, bad frame, full or empty list results need no list walk; otherwise the list
// engine walks the cnt stored IDs, one read a cycle, before the result is registered.
// Throughput: one input beat per cycle while the 2-deep job queue has room; the list
// engine finishes one job, through its result, before it pops the next.
// Reset (rst_n low, synchronous) empties the list, restarts framing, loads defaults.
module card_frame_check_and_id_allowlist_core #(
  parameter int unsigned CAPACITY = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] rx_byte
  input  logic [1:0]  in_tuser,    // [0] cmd, [1] frame_start
  // Result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,   // [31:0] card_id, [39:32] card_count, [40] beep, zero pad
  output logic [2:0]  out_tuser,   // [2:0] status
  // Configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [cfcid_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]  cfg_data
);
  import cfcid_pkg::*;

  logic       enroll_mode_r, enroll_mode_nxt;
  logic [7:0] max_cards_r, max_cards_nxt;

  logic       in_fire;
  logic       q_push, q_full, q_pop, q_valid;
  job_t       q_in_job, q_head_job;

  assign cfg_ready = 1'b1;
  assign in_tready = !q_full;
  assign in_fire   = in_tvalid && in_tready;

  // Configuration registers
  always_comb begin
    enroll_mode_nxt = enroll_mode_r;
    max_cards_nxt   = max_cards_r;
    if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_IDX_ENROLL) begin
        enroll_mode_nxt = cfg_data[0];
      end else if (cfg_index == CFG_IDX_MAX) begin
        max_cards_nxt = cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enroll_mode_r <= 1'b0;
      max_cards_r   <= MAX_CARDS_RST;
    end else begin
      enroll_mode_r <= enroll_mode_nxt;
      max_cards_r   <= max_cards_nxt;
    end
  end

  cfcid_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_fire     (in_fire),
    .cmd         (in_tuser[0]),
    .frame_start (in_tuser[1]),
    .rx_byte     (in_tdata),
    .enroll_mode (enroll_mode_r),
    .push        (q_push),
    .push_job    (q_in_job)
  );

  cfcid_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (q_in_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_job   (q_head_job)
  );

  cfcid_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_valid),
    .head_job   (q_head_job),
    .pop        (q_pop),
    .max_cards  (max_cards_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

>>> hdl/cfcid_front.sv
// Frame parser: accepts input beats, tracks byte position, XOR check and ID.
// Emits one job per erase command or completed frame into the job queue.
// Depends on cfcid_pkg.
module cfcid_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  logic                cmd,
  input  logic                frame_start,
  input  logic [7:0]          rx_byte,
  input  logic                enroll_mode,
  output logic                push,
  output cfcid_pkg::job_t     push_job
);
  import cfcid_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       xor_r, xor_nxt;
  logic             ok_r, ok_nxt;
  logic [31:0]      id_r, id_nxt;
  logic [7:0]       chk_r, chk_nxt;

  logic [POS_W-1:0] pos_e;
  logic [7:0]       xor_e;
  logic             ok_e;
  logic [31:0]      id_e;
  logic [7:0]       chk_e;
  logic             frame_bad;

  // Restart the frame state when the start mark is set
  always_comb begin
    pos_e = frame_start ? POS_FIRST : pos_r;
    xor_e = frame_start ? 8'd0 : xor_r;
    ok_e  = frame_start ? 1'b0 : ok_r;
    id_e  = frame_start ? 32'd0 : id_r;
    chk_e = frame_start ? 8'd0 : chk_r;
  end

  assign frame_bad = !ok_e || (rx_byte != END_MARK) || (chk_e != ~xor_e);

  // Advance the frame state and build a job on the last byte or an erase
  always_comb begin
    pos_nxt  = pos_r;
    xor_nxt  = xor_r;
    ok_nxt   = ok_r;
    id_nxt   = id_r;
    chk_nxt  = chk_r;
    push     = 1'b0;
    push_job = '{kind: JOB_ERASE, id: 32'd0};
    if (in_fire) begin
      if (cmd) begin
        push = 1'b1;
      end else if (pos_e < POS_END) begin
        xor_nxt = xor_e;
        ok_nxt  = ok_e;
        id_nxt  = id_e;
        chk_nxt = chk_e;
        if (pos_e == POS_FIRST) begin
          ok_nxt = (rx_byte == START_MARK);
        end
        if (pos_e < POS_CHECK) begin
          xor_nxt = xor_e ^ rx_byte;
        end
        if (pos_e >= POS_ID_LO && pos_e <= POS_ID_HI) begin
          id_nxt = {id_e[23:0], rx_byte};
        end
        if (pos_e == POS_CHECK) begin
          chk_nxt = rx_byte;
        end
        pos_nxt = pos_e + 4'd1;
        if (pos_e == POS_LAST) begin
          push        = 1'b1;
          push_job.id = id_e;
          if (frame_bad) begin
            push_job.kind = JOB_BAD;
          end else if (enroll_mode) begin
            push_job.kind = JOB_ENROLL;
          end else begin
            push_job.kind = JOB_CHECK;
          end
        end
      end
    end
  end

  // Hold frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_FIRST;
      xor_r <= 8'd0;
      ok_r  <= 1'b0;
      id_r  <= 32'd0;
      chk_r <= 8'd0;
    end else begin
      pos_r <= pos_nxt;
      xor_r <= xor_nxt;
      ok_r  <= ok_nxt;
      id_r  <= id_nxt;
      chk_r <= chk_nxt;
    end
  end

endmodule

>>> hdl/cfcid_queue.sv
// Short job queue between the frame parser and the list engine.
// Register-based FIFO of Q_DEPTH jobs with registered occupancy.
// Depends on cfcid_pkg.
module cfcid_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  cfcid_pkg::job_t   push_job,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output cfcid_pkg::job_t   head_job
);
  import cfcid_pkg::*;

  localparam int unsigned QW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned CW = $clog2(Q_DEPTH + 1);

  job_t          slot_r [Q_DEPTH];
  logic [QW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full       = (cnt_r == CW'(Q_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_job   = slot_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + QW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + QW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store payload, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

>>> hdl/cfcid_back.sv
// List engine: pops jobs, walks the ID memory, updates the count, drives results.
// Owns the ID memory, the stored count and the output register.
// Depends on cfcid_pkg.
module cfcid_back #(
  parameter int unsigned CAPACITY = 128
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  cfcid_pkg::job_t   head_job,
  output logic              pop,
  input  logic [7:0]        max_cards,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [47:0]       out_tdata,
  output logic [2:0]        out_tuser
);
  import cfcid_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [7:0] CAP_LIM = (CAPACITY > 255) ? 8'd255 : 8'(CAPACITY);

  back_state_t state_r, state_nxt;
  job_t        job_r, job_nxt;
  status_t     st_r, st_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic [7:0]  ptr_r, ptr_nxt;
  logic        pend_r, pend_nxt;
  logic        pend_last_r, pend_last_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [47:0] out_data_r, out_data_nxt;
  logic [2:0]  out_user_r, out_user_nxt;

  logic [31:0] mem [CAPACITY];
  logic [31:0] rd_data_r;
  logic        wr_en;
  logic [31:0] wr_id;
  logic [AW+7:0] rd_ext, wr_ext;
  logic [AW-1:0] rd_addr, wr_addr;
  logic        rd_en;

  logic [7:0]  limit;
  logic        out_free;
  logic        hit;
  logic [31:0] res_id;
  logic        res_beep;

  assign limit    = (max_cards < CAP_LIM) ? max_cards : CAP_LIM;
  assign out_free = !out_valid_r || out_tready;
  assign hit      = pend_r && (rd_data_r == job_r.id);

  assign rd_ext  = {{AW{1'b0}}, ptr_r};
  assign wr_ext  = {{AW{1'b0}}, cnt_r};
  assign rd_addr = rd_ext[AW-1:0];
  assign wr_addr = wr_ext[AW-1:0];

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (head_valid) begin
          unique case (head_job.kind)
            JOB_ENROLL: begin
              state_nxt = (cnt_r >= limit || cnt_r == 8'd0) ? BK_EMIT : BK_SEARCH;
            end
            JOB_CHECK: state_nxt = (cnt_r == 8'd0) ? BK_EMIT : BK_SEARCH;
            JOB_ERASE, JOB_BAD: state_nxt = BK_EMIT;
            default: state_nxt = BK_EMIT;
          endcase
        end
      end
      BK_SEARCH: begin
        if (hit || (pend_r && pend_last_r)) begin
          state_nxt = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (out_free) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Datapath and control outputs
  always_comb begin
    pop           = 1'b0;
    job_nxt       = job_r;
    st_nxt        = st_r;
    cnt_nxt       = cnt_r;
    ptr_nxt       = ptr_r;
    pend_nxt      = 1'b0;
    pend_last_nxt = 1'b0;
    wr_en         = 1'b0;
    wr_id         = job_r.id;
    rd_en         = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        ptr_nxt = 8'd0;
        if (head_valid) begin
          pop     = 1'b1;
          job_nxt = head_job;
          unique case (head_job.kind)
            JOB_ERASE: begin
              cnt_nxt = 8'd0;
              st_nxt  = ST_ERASED;
            end
            JOB_BAD: st_nxt = ST_BAD;
            JOB_ENROLL: begin
              if (cnt_r >= limit) begin
                st_nxt = ST_FULL;
              end else if (cnt_r == 8'd0) begin
                // Empty list: append without a walk
                wr_en   = 1'b1;
                wr_id   = head_job.id;
                cnt_nxt = cnt_r + 8'd1;
                st_nxt  = ST_ENROLLED;
              end
            end
            JOB_CHECK: begin
              if (cnt_r == 8'd0) begin
                st_nxt = ST_UNKNOWN;
              end
            end
            default: st_nxt = ST_BAD;
          endcase
        end
      end
      BK_SEARCH: begin
        if (hit) begin
          st_nxt = (job_r.kind == JOB_ENROLL) ? ST_DUP : ST_GRANTED;
        end else if (pend_r && pend_last_r) begin
          if (job_r.kind == JOB_ENROLL) begin
            wr_en   = 1'b1;
            cnt_nxt = cnt_r + 8'd1;
            st_nxt  = ST_ENROLLED;
          end else begin
            st_nxt = ST_UNKNOWN;
          end
        end else if (ptr_r < cnt_r) begin
          // Issue the next read of the walk
          rd_en         = 1'b1;
          ptr_nxt       = ptr_r + 8'd1;
          pend_nxt      = 1'b1;
          pend_last_nxt = (ptr_r == cnt_r - 8'd1);
        end
      end
      BK_EMIT: ;
      default: ;
    endcase
  end

  // Result payload and output register
  assign res_id   = (st_r == ST_ERASED) ? 32'd0 : job_r.id;
  assign res_beep = (st_r == ST_ENROLLED) || (st_r == ST_GRANTED) || (st_r == ST_ERASED);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (state_r == BK_EMIT && out_free) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {7'd0, res_beep, cnt_r, res_id};
      out_user_nxt  = st_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      cnt_r       <= 8'd0;
      ptr_r       <= 8'd0;
      pend_r      <= 1'b0;
      pend_last_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ptr_r       <= ptr_nxt;
      pend_r      <= pend_nxt;
      pend_last_r <= pend_last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold job and result payload
  always_ff @(posedge clk) begin
    job_r      <= job_nxt;
    st_r       <= st_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  // ID memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_id;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

>>> hdl/cfcid_checker.sv
// Port-level checks for the card frame checker and ID allow-list.
// Bound to card_frame_check_and_id_allowlist_core; depends on cfcid_pkg.
module cfcid_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic [2:0]  out_tuser
);
  import cfcid_pkg::*;

  // Result beat stays put while stalled
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // Erase reports an empty list and no ID
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_ERASED |-> out_tdata[39:0] == 40'd0)
    else $error("erase result carries a count or ID");

  // Beep follows the status
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[40] == (out_tuser == ST_ENROLLED || out_tuser == ST_GRANTED
                                     || out_tuser == ST_ERASED))
    else $error("beep does not match status");

  // A fresh enrollment leaves at least one stored ID
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_ENROLLED |-> out_tdata[39:32] != 8'd0)
    else $error("enrolled with empty list");

  // Output register is empty right after reset
  assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind card_frame_check_and_id_allowlist_core cfcid_checker u_cfcid_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
